// File: rtl/bpc_pkg.sv
`default_nettype none

package bpc_pkg;

    // shared multiplier operand and result widths
    localparam int MX_W   = 37;
    localparam int MY_W   = 33;
    localparam int PROD_W = 64;
    localparam int ACC_W  = 56;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DOT,
        ST_RAD,
        ST_DIST,
        ST_TEST,
        ST_TERM,
        ST_VTX,
        ST_FLUSH
    } state_t;

    typedef enum logic [2:0] {
        REG_NORMAL_X      = 3'd0,
        REG_NORMAL_Y      = 3'd1,
        REG_NORMAL_Z      = 3'd2,
        REG_PLANE_OFFSET  = 3'd3,
        REG_CONTACT_LIMIT = 3'd4
    } cfg_reg_t;

    localparam logic [1:0] SLOT_CENTRE  = 2'd3;
    localparam logic [3:0] MAX_CONTACTS = 4'd8;

    typedef struct packed {
        logic acc_clr;
        logic acc_add;
    } mac_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/bpc_mac.sv
`default_nettype none

module bpc_mac
    import bpc_pkg::*;
(
    input  wire                            clk,
    input  wire logic signed [MX_W-1:0]    op_x,
    input  wire logic signed [MY_W-1:0]    op_y,
    input  wire mac_ctrl_t                 ctrl,
    output logic signed [PROD_W-1:0]       prod,
    output logic signed [ACC_W-1:0]        acc
);

    logic signed [MX_W+MY_W-1:0] full;
    logic signed [PROD_W-1:0]    prod_reg;
    logic signed [PROD_W-1:0]    prod_next;
    logic signed [ACC_W-1:0]     acc_reg;
    logic signed [ACC_W-1:0]     acc_next;
    logic signed [ACC_W-1:0]     addend;

    // product registered before it reaches the accumulator
    assign full      = op_x * op_y;
    assign prod_next = full[PROD_W-1:0];
    assign addend    = ctrl.acc_add ? prod_reg[ACC_W-1:0] : '0;
    assign acc_next  = (ctrl.acc_clr ? '0 : acc_reg) + addend;

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

    assign prod = prod_reg;
    assign acc  = acc_reg;

endmodule

`default_nettype wire

// File: rtl/box_plane_contact.sv
`default_nettype none

// channel   direction  handshake                payload
// box       in         box_valid / box_stall    slot, axis_x/y/z, half_size, centre_x/y/z
// contact   out        contact_valid / stall    hit, corner, point_x/y/z, depth, last
// cfg       in         cfg_valid / cfg_ready    cfg_index, cfg_data
//
// axis requests (slot 0 to 2) are stored while idle, without raising box_stall; a
// centre request runs one shared multiplier under the sequencer, which rejects the
// box early or visits up to all eight corners
// rst_n clears the sequencer, stored axes and extents, and loads register defaults
// box_stall stays high while a box is at work; a stalled contact output holds the
// sequencer only where a new contact has to be handed over

module box_plane_contact
    import bpc_pkg::*;
(
    input  wire                       clk,
    input  wire                       rst_n,
    // box requests
    input  wire                       box_valid,
    output logic                      box_stall,
    input  wire  [1:0]                slot,
    input  wire  signed [15:0]        axis_x,
    input  wire  signed [15:0]        axis_y,
    input  wire  signed [15:0]        axis_z,
    input  wire  [30:0]               half_size,
    input  wire  signed [31:0]        centre_x,
    input  wire  signed [31:0]        centre_y,
    input  wire  signed [31:0]        centre_z,
    // contact results
    output logic                      contact_valid,
    input  wire                       contact_stall,
    output logic                      hit,
    output logic [2:0]                corner,
    output logic signed [31:0]        point_x,
    output logic signed [31:0]        point_y,
    output logic signed [31:0]        point_z,
    output logic [30:0]               depth,
    output logic                      last,
    // configuration writes
    input  wire                       cfg_valid,
    output logic                      cfg_ready,
    input  wire  [2:0]                cfg_index,
    input  wire  [31:0]               cfg_data
);

    function automatic logic signed [15:0] axis_comp(input logic [47:0] a,
                                                     input logic [1:0] k);
        case (k)
            2'd0:    axis_comp = a[15:0];
            2'd1:    axis_comp = a[31:16];
            default: axis_comp = a[47:32];
        endcase
    endfunction

    function automatic logic [31:0] sat32(input logic signed [36:0] v);
        if (v > 37'sh0_7FFF_FFFF)
            sat32 = 32'h7FFF_FFFF;
        else if (v < -37'sh0_8000_0000)
            sat32 = 32'h8000_0000;
        else
            sat32 = v[31:0];
    endfunction

    // sequencer and control
    state_t      state_reg, state_next;
    logic [1:0]  i_reg, i_next;
    logic [1:0]  k_reg, k_next;
    logic [1:0]  ph_reg, ph_next;
    logic [2:0]  crn_reg, crn_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [3:0]  lim_reg, lim_next;

    // configuration
    logic signed [15:0] nx_reg, nx_next;
    logic signed [15:0] ny_reg, ny_next;
    logic signed [15:0] nz_reg, nz_next;
    logic signed [31:0] off_reg, off_next;
    logic [3:0]         limit_reg, limit_next;

    // box stores
    logic [47:0] axis_reg [0:2];
    logic [47:0] axis_next [0:2];
    logic [30:0] ext_reg [0:2];
    logic [30:0] ext_next [0:2];

    // working values
    logic signed [31:0] cx_reg, cx_next, cy_reg, cy_next, cz_reg, cz_next;
    logic [31:0]        d_reg, d_next;
    logic [37:0]        rad_reg, rad_next;
    logic signed [41:0] dist_reg, dist_next;
    logic signed [47:0] t_reg [0:8];
    logic signed [47:0] t_next [0:8];
    logic signed [36:0] v_reg [0:2];
    logic signed [36:0] v_next [0:2];

    // held contact, sent once the next one or the end is known
    logic        pv_reg, pv_next;
    logic [2:0]  pc_reg, pc_next;
    logic [31:0] ppx_reg, ppx_next, ppy_reg, ppy_next, ppz_reg, ppz_next;
    logic [30:0] pd_reg, pd_next;

    // output register
    logic        ov_reg, ov_next;
    logic        oh_reg, oh_next;
    logic [2:0]  oc_reg, oc_next;
    logic [31:0] opx_reg, opx_next, opy_reg, opy_next, opz_reg, opz_next;
    logic [30:0] od_reg, od_next;
    logic        ol_reg, ol_next;

    // shared multiplier
    logic signed [MX_W-1:0]   op_x;
    logic signed [MY_W-1:0]   op_y;
    mac_ctrl_t                mac_ctrl;
    logic signed [PROD_W-1:0] prod;
    logic signed [ACC_W-1:0]  acc;

    logic signed [15:0] n_sel;
    logic signed [15:0] a_sel;
    logic signed [31:0] c_sel;
    logic [3:0]         tidx;
    logic signed [49:0] vsum;
    logic signed [36:0] vnew;
    logic signed [32:0] dsig;
    logic signed [41:0] vd;
    logic signed [43:0] margin;
    logic signed [43:0] dep;
    logic [30:0]        dep_sat;
    logic               qual;
    logic               out_free;
    logic [3:0]         cnt_inc;

    bpc_mac u_mac (
        .clk  (clk),
        .op_x (op_x),
        .op_y (op_y),
        .ctrl (mac_ctrl),
        .prod (prod),
        .acc  (acc)
    );

    assign n_sel = (k_reg == 2'd0) ? nx_reg : ((k_reg == 2'd1) ? ny_reg : nz_reg);
    assign c_sel = (k_reg == 2'd0) ? cx_reg : ((k_reg == 2'd1) ? cy_reg : cz_reg);
    assign a_sel = axis_comp(axis_reg[i_reg], k_reg);
    assign tidx  = {2'b00, i_reg} * 4'd3 + {2'b00, k_reg};

    // corner offset: bit j of the corner index picks the negative half size
    assign vsum = (crn_reg[0] ? -50'(t_reg[{2'b00, k_reg}]) : 50'(t_reg[{2'b00, k_reg}]))
                + (crn_reg[1] ? -50'(t_reg[4'd3 + {2'b00, k_reg}])
                              : 50'(t_reg[4'd3 + {2'b00, k_reg}]))
                + (crn_reg[2] ? -50'(t_reg[4'd6 + {2'b00, k_reg}])
                              : 50'(t_reg[4'd6 + {2'b00, k_reg}]));
    assign vnew = 37'(c_sel) + 37'(vsum >>> 14);

    assign dsig    = acc[32:0];
    assign vd      = 42'(acc >>> 14);
    assign margin  = 44'(dist_reg) - 44'($signed({1'b0, rad_reg}));
    assign qual    = 44'(vd) <= 44'(off_reg);
    assign dep     = 44'(off_reg) - 44'(vd);
    assign dep_sat = (dep > 44'sh000_7FFF_FFFF) ? 31'h7FFF_FFFF : dep[30:0];
    assign cnt_inc = cnt_reg + {3'b000, qual};

    assign out_free = !ov_reg || !contact_stall;

    // operand select for the shared multiplier
    always_comb
    begin
        op_x = '0;
        op_y = '0;
        case (state_reg)
            ST_DOT:
            begin
                op_x = 37'(a_sel);
                op_y = 33'(n_sel);
            end
            ST_RAD:
            begin
                op_x = $signed({6'b0, ext_reg[i_reg]});
                op_y = $signed({1'b0, d_reg});
            end
            ST_DIST:
            begin
                op_x = 37'(c_sel);
                op_y = 33'(n_sel);
            end
            ST_TERM:
            begin
                op_x = $signed({6'b0, ext_reg[i_reg]});
                op_y = 33'(a_sel);
            end
            ST_VTX:
            begin
                op_x = v_reg[k_reg];
                op_y = 33'(n_sel);
            end
            default:
            begin
                op_x = '0;
                op_y = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        k_next     = k_reg;
        ph_next    = ph_reg;
        crn_next   = crn_reg;
        cnt_next   = cnt_reg;
        lim_next   = lim_reg;
        nx_next    = nx_reg;
        ny_next    = ny_reg;
        nz_next    = nz_reg;
        off_next   = off_reg;
        limit_next = limit_reg;
        axis_next  = axis_reg;
        ext_next   = ext_reg;
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        cz_next    = cz_reg;
        d_next     = d_reg;
        rad_next   = rad_reg;
        dist_next  = dist_reg;
        t_next     = t_reg;
        v_next     = v_reg;
        pv_next    = pv_reg;
        pc_next    = pc_reg;
        ppx_next   = ppx_reg;
        ppy_next   = ppy_reg;
        ppz_next   = ppz_reg;
        pd_next    = pd_reg;
        ov_next    = ov_reg && contact_stall;
        oh_next    = oh_reg;
        oc_next    = oc_reg;
        opx_next   = opx_reg;
        opy_next   = opy_reg;
        opz_next   = opz_reg;
        od_next    = od_reg;
        ol_next    = ol_reg;
        mac_ctrl   = '0;
        box_stall  = (state_reg != ST_IDLE);

        if (cfg_valid)
        begin
            case (cfg_index)
                REG_NORMAL_X:      nx_next    = cfg_data[15:0];
                REG_NORMAL_Y:      ny_next    = cfg_data[15:0];
                REG_NORMAL_Z:      nz_next    = cfg_data[15:0];
                REG_PLANE_OFFSET:  off_next   = cfg_data;
                REG_CONTACT_LIMIT: limit_next = cfg_data[3:0];
                default:           ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (box_valid)
                begin
                    if (slot != SLOT_CENTRE)
                    begin
                        axis_next[slot] = {axis_z, axis_y, axis_x};
                        ext_next[slot]  = half_size;
                    end
                    else
                    begin
                        cx_next   = centre_x;
                        cy_next   = centre_y;
                        cz_next   = centre_z;
                        lim_next  = (limit_reg > MAX_CONTACTS) ? MAX_CONTACTS : limit_reg;
                        i_next    = '0;
                        k_next    = '0;
                        ph_next   = '0;
                        cnt_next  = '0;
                        rad_next  = '0;
                        pv_next   = 1'b0;
                        mac_ctrl.acc_clr = 1'b1;
                        state_next = ST_DOT;
                    end
                end
            end

            // normal dot box axis i
            ST_DOT:
            begin
                case (ph_reg)
                    2'd0:
                        ph_next = 2'd1;
                    2'd1:
                    begin
                        mac_ctrl.acc_add = 1'b1;
                        if (k_reg == 2'd2)
                            ph_next = 2'd2;
                        else
                        begin
                            k_next  = k_reg + 2'd1;
                            ph_next = 2'd0;
                        end
                    end
                    default:
                    begin
                        d_next = dsig[32] ? 32'(-dsig) : dsig[31:0];
                        mac_ctrl.acc_clr = 1'b1;
                        k_next     = '0;
                        ph_next    = '0;
                        state_next = ST_RAD;
                    end
                endcase
            end

            // projected radius term
            ST_RAD:
            begin
                if (ph_reg == 2'd0)
                    ph_next = 2'd1;
                else
                begin
                    rad_next = rad_reg + 38'(prod[63:28]);
                    ph_next  = '0;
                    if (i_reg == 2'd2)
                    begin
                        i_next     = '0;
                        state_next = ST_DIST;
                    end
                    else
                    begin
                        i_next     = i_reg + 2'd1;
                        state_next = ST_DOT;
                    end
                end
            end

            // centre distance along the normal
            ST_DIST:
            begin
                case (ph_reg)
                    2'd0:
                        ph_next = 2'd1;
                    2'd1:
                    begin
                        mac_ctrl.acc_add = 1'b1;
                        if (k_reg == 2'd2)
                            ph_next = 2'd2;
                        else
                        begin
                            k_next  = k_reg + 2'd1;
                            ph_next = 2'd0;
                        end
                    end
                    default:
                    begin
                        dist_next = vd;
                        mac_ctrl.acc_clr = 1'b1;
                        k_next     = '0;
                        ph_next    = '0;
                        state_next = ST_TEST;
                    end
                endcase
            end

            ST_TEST:
            begin
                if (lim_reg == 4'd0 || margin > 44'(off_reg))
                    state_next = ST_FLUSH;
                else
                begin
                    i_next     = '0;
                    k_next     = '0;
                    ph_next    = '0;
                    state_next = ST_TERM;
                end
            end

            // half size times axis component, shared by all corners
            ST_TERM:
            begin
                if (ph_reg == 2'd0)
                    ph_next = 2'd1;
                else
                begin
                    t_next[tidx] = prod[47:0];
                    ph_next = '0;
                    if (k_reg == 2'd2)
                    begin
                        k_next = '0;
                        if (i_reg == 2'd2)
                        begin
                            i_next     = '0;
                            crn_next   = '0;
                            state_next = ST_VTX;
                        end
                        else
                            i_next = i_reg + 2'd1;
                    end
                    else
                        k_next = k_reg + 2'd1;
                end
            end

            // one corner: build each component, then its distance
            ST_VTX:
            begin
                case (ph_reg)
                    2'd0:
                    begin
                        v_next[k_reg] = vnew;
                        ph_next = 2'd1;
                    end
                    2'd1:
                        ph_next = 2'd2;
                    2'd2:
                    begin
                        mac_ctrl.acc_add = 1'b1;
                        if (k_reg == 2'd2)
                            ph_next = 2'd3;
                        else
                        begin
                            k_next  = k_reg + 2'd1;
                            ph_next = 2'd0;
                        end
                    end
                    default:
                    begin
                        // wait only when a held contact must leave first
                        if (!(qual && pv_reg && !out_free))
                        begin
                            if (qual)
                            begin
                                if (pv_reg)
                                begin
                                    ov_next  = 1'b1;
                                    oh_next  = 1'b1;
                                    oc_next  = pc_reg;
                                    opx_next = ppx_reg;
                                    opy_next = ppy_reg;
                                    opz_next = ppz_reg;
                                    od_next  = pd_reg;
                                    ol_next  = 1'b0;
                                end
                                pv_next  = 1'b1;
                                pc_next  = crn_reg;
                                ppx_next = sat32(v_reg[0]);
                                ppy_next = sat32(v_reg[1]);
                                ppz_next = sat32(v_reg[2]);
                                pd_next  = dep_sat;
                            end
                            cnt_next = cnt_inc;
                            mac_ctrl.acc_clr = 1'b1;
                            k_next  = '0;
                            ph_next = '0;
                            if (crn_reg == 3'd7 || cnt_inc == lim_reg)
                                state_next = ST_FLUSH;
                            else
                                crn_next = crn_reg + 3'd1;
                        end
                    end
                endcase
            end

            // final contact of the box: held contact or a miss
            ST_FLUSH:
            begin
                if (out_free)
                begin
                    ov_next = 1'b1;
                    ol_next = 1'b1;
                    if (pv_reg)
                    begin
                        oh_next  = 1'b1;
                        oc_next  = pc_reg;
                        opx_next = ppx_reg;
                        opy_next = ppy_reg;
                        opz_next = ppz_reg;
                        od_next  = pd_reg;
                    end
                    else
                    begin
                        oh_next  = 1'b0;
                        oc_next  = '0;
                        opx_next = '0;
                        opy_next = '0;
                        opz_next = '0;
                        od_next  = '0;
                    end
                    pv_next    = 1'b0;
                    state_next = ST_IDLE;
                end
            end

            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            i_reg     <= '0;
            k_reg     <= '0;
            ph_reg    <= '0;
            crn_reg   <= '0;
            cnt_reg   <= '0;
            lim_reg   <= '0;
            nx_reg    <= 16'sd0;
            ny_reg    <= 16'sd16384;
            nz_reg    <= 16'sd0;
            off_reg   <= '0;
            limit_reg <= MAX_CONTACTS;
            pv_reg    <= 1'b0;
            ov_reg    <= 1'b0;
            for (int e = 0; e < 3; e++)
            begin
                axis_reg[e] <= '0;
                ext_reg[e]  <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            k_reg     <= k_next;
            ph_reg    <= ph_next;
            crn_reg   <= crn_next;
            cnt_reg   <= cnt_next;
            lim_reg   <= lim_next;
            nx_reg    <= nx_next;
            ny_reg    <= ny_next;
            nz_reg    <= nz_next;
            off_reg   <= off_next;
            limit_reg <= limit_next;
            pv_reg    <= pv_next;
            ov_reg    <= ov_next;
            axis_reg  <= axis_next;
            ext_reg   <= ext_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        cx_reg   <= cx_next;
        cy_reg   <= cy_next;
        cz_reg   <= cz_next;
        d_reg    <= d_next;
        rad_reg  <= rad_next;
        dist_reg <= dist_next;
        t_reg    <= t_next;
        v_reg    <= v_next;
        pc_reg   <= pc_next;
        ppx_reg  <= ppx_next;
        ppy_reg  <= ppy_next;
        ppz_reg  <= ppz_next;
        pd_reg   <= pd_next;
        oh_reg   <= oh_next;
        oc_reg   <= oc_next;
        opx_reg  <= opx_next;
        opy_reg  <= opy_next;
        opz_reg  <= opz_next;
        od_reg   <= od_next;
        ol_reg   <= ol_next;
    end

    assign cfg_ready     = 1'b1;
    assign contact_valid = ov_reg;
    assign hit           = oh_reg;
    assign corner        = oc_reg;
    assign point_x       = opx_reg;
    assign point_y       = opy_reg;
    assign point_z       = opz_reg;
    assign depth         = od_reg;
    assign last          = ol_reg;

endmodule

`default_nettype wire

// File: tb/sv/tb_box_plane_contact.sv
module tb_box_plane_contact;
    import bpc_pkg::*;

    // contact result as it appears on the output ports
    typedef struct packed {
        logic        hit;
        logic [2:0]  corner;
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] pz;
        logic [30:0] depth;
        logic        last;
    } contact_t;

    // one box request
    typedef struct packed {
        logic [1:0]         slot;
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
        logic [30:0]        half;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] cz;
    } box_req_t;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 200;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic               box_valid = 1'b0;
    logic               box_stall;
    logic [1:0]         slot = '0;
    logic signed [15:0] axis_x = '0, axis_y = '0, axis_z = '0;
    logic [30:0]        half_size = '0;
    logic signed [31:0] centre_x = '0, centre_y = '0, centre_z = '0;
    logic               contact_valid;
    logic               contact_stall = 1'b0;
    logic               hit;
    logic [2:0]         corner;
    logic signed [31:0] point_x, point_y, point_z;
    logic [30:0]        depth;
    logic               last;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [2:0]         cfg_index = '0;
    logic [31:0]        cfg_data = '0;

    always #2 clk = ~clk;

    box_plane_contact DUT (
        .clk(clk), .rst_n(rst_n),
        .box_valid(box_valid), .box_stall(box_stall), .slot(slot),
        .axis_x(axis_x), .axis_y(axis_y), .axis_z(axis_z), .half_size(half_size),
        .centre_x(centre_x), .centre_y(centre_y), .centre_z(centre_z),
        .contact_valid(contact_valid), .contact_stall(contact_stall),
        .hit(hit), .corner(corner), .point_x(point_x), .point_y(point_y),
        .point_z(point_z), .depth(depth), .last(last),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // predictor copy of the block state and registers
    logic signed [15:0] pl_axis [3][3];
    logic [30:0]        pl_half [3];
    logic signed [15:0] pl_n [3];
    logic signed [31:0] pl_offset;
    logic [3:0]         pl_limit;

    contact_t pending_contacts[$];
    int       mismatches = 0;
    bit       timed_out = 1'b0;
    bit       idle_on = 1'b1;
    int       quiet_cycles = 0;
    int       contact_count = 0;
    int       stall_left = 0;

    function automatic logic signed [63:0] floor_div14(logic signed [63:0] v);
        // arithmetic shift rounds toward minus infinity
        return v >>> 14;
    endfunction

    function automatic logic [31:0] clamp32(logic signed [63:0] v);
        if (v > 64'sd2147483647) return 32'h7fffffff;
        if (v < -64'sd2147483648) return 32'h80000000;
        return v[31:0];
    endfunction

    // loads an axis or evaluates a box against the plane, queueing the contacts
    task automatic predict_contacts(input box_req_t r);
        logic signed [63:0] radius, cdist, d, acc, vd, dep;
        logic signed [63:0] c [3];
        logic signed [63:0] v [3];
        int lim, cnt;
        contact_t e;
        radius = 0;
        cnt = 0;
        if (r.slot != SLOT_CENTRE) begin
            pl_axis[r.slot][0] = r.ax;
            pl_axis[r.slot][1] = r.ay;
            pl_axis[r.slot][2] = r.az;
            pl_half[r.slot] = r.half;
            return;
        end
        c[0] = r.cx; c[1] = r.cy; c[2] = r.cz;
        lim = (pl_limit > MAX_CONTACTS) ? MAX_CONTACTS : pl_limit;
        for (int i = 0; i < 3; i++) begin
            d = 0;
            for (int k = 0; k < 3; k++) d += 64'(pl_n[k]) * 64'(pl_axis[i][k]);
            if (d < 0) d = -d;
            radius += (64'($unsigned(pl_half[i])) * d) >>> 28;
        end
        cdist = floor_div14(64'(pl_n[0]) * c[0] + 64'(pl_n[1]) * c[1]
                            + 64'(pl_n[2]) * c[2]);
        if (lim > 0 && cdist - radius <= 64'(pl_offset)) begin
            for (int i = 0; i < 8 && cnt < lim; i++) begin
                vd = 0;
                for (int k = 0; k < 3; k++) begin
                    acc = 0;
                    for (int j = 0; j < 3; j++) begin
                        // corner bit j set takes the negative half extent
                        if (i[j]) acc -= 64'($unsigned(pl_half[j])) * 64'(pl_axis[j][k]);
                        else      acc += 64'($unsigned(pl_half[j])) * 64'(pl_axis[j][k]);
                    end
                    v[k] = c[k] + floor_div14(acc);
                    vd += 64'(pl_n[k]) * v[k];
                end
                vd = floor_div14(vd);
                if (vd <= 64'(pl_offset)) begin
                    dep = 64'(pl_offset) - vd;
                    if (dep > 64'sh7fffffff) dep = 64'sh7fffffff;
                    e.hit = 1'b1;
                    e.corner = i[2:0];
                    e.px = clamp32(v[0]);
                    e.py = clamp32(v[1]);
                    e.pz = clamp32(v[2]);
                    e.depth = dep[30:0];
                    e.last = 1'b0;
                    pending_contacts.push_back(e);
                    cnt++;
                end
            end
        end
        if (cnt == 0) begin
            e = '0;
            e.last = 1'b1;
            pending_contacts.push_back(e);
        end else begin
            pending_contacts[pending_contacts.size() - 1].last = 1'b1;
        end
    endtask

    task automatic apply_cfg(input cfg_reg_t idx, input logic [31:0] val);
        case (idx)
            REG_NORMAL_X:      pl_n[0] = val[15:0];
            REG_NORMAL_Y:      pl_n[1] = val[15:0];
            REG_NORMAL_Z:      pl_n[2] = val[15:0];
            REG_PLANE_OFFSET:  pl_offset = val;
            REG_CONTACT_LIMIT: pl_limit = val[3:0];
            default: ;
        endcase
    endtask

    // register write at the falling edge, held until ready; caller drops valid
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        if (idx <= 3'(REG_CONTACT_LIMIT)) apply_cfg(cfg_reg_t'(idx), val);
        @(negedge clk);
    endtask

    // optional random gap, then one request held until accepted
    task automatic send_box(input box_req_t r);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            box_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
        box_valid <= 1'b1;
        slot <= r.slot;
        axis_x <= r.ax; axis_y <= r.ay; axis_z <= r.az;
        half_size <= r.half;
        centre_x <= r.cx; centre_y <= r.cy; centre_z <= r.cz;
        @(posedge clk);
        while (box_stall) @(posedge clk);
        predict_contacts(r);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        box_valid <= 1'b0;
        while (pending_contacts.size() != 0 && !timed_out) @(negedge clk);
        // the block may still be finishing after its last contact
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    function automatic box_req_t axis_req(input logic [1:0] s, input logic [15:0] x,
                                          input logic [15:0] y, input logic [15:0] z,
                                          input logic [30:0] h);
        box_req_t r;
        r = '0;
        r.slot = s; r.ax = x; r.ay = y; r.az = z; r.half = h;
        return r;
    endfunction

    function automatic box_req_t centre_req(input logic [31:0] x, input logic [31:0] y,
                                            input logic [31:0] z);
        box_req_t r;
        r = '0;
        r.slot = SLOT_CENTRE; r.cx = x; r.cy = y; r.cz = z;
        return r;
    endfunction

    function automatic logic [15:0] rand_comp();
        case ($urandom_range(0, 4))
            0: return 16'sd16384;
            1: return -16'sd16384;
            2: return 16'(0);
            default: return 16'($urandom_range(0, 16'hffff));
        endcase
    endfunction

    function automatic logic [30:0] rand_half();
        case ($urandom_range(0, 5))
            0: return 31'h7fffffff;
            1: return 31'(0);
            default: return 31'($urandom_range(0, 32'h0008_0000));
        endcase
    endfunction

    function automatic logic [31:0] rand_pos();
        case ($urandom_range(0, 6))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom();
            default: return 32'($signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000);
        endcase
    endfunction

    // output side: random stall bursts
    always @(negedge clk) begin
        if (!idle_on || !rst_n) begin
            contact_stall <= 1'b0;
            stall_left = 0;
        end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            if (stall_left == 0) contact_stall <= 1'b0;
        end else if ($urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 18);
            contact_stall <= 1'b1;
        end
    end

    // checking against the oldest prediction
    always @(posedge clk) begin
        contact_t got, want;
        if (rst_n && contact_valid && !contact_stall) begin
            got = {hit, corner, point_x, point_y, point_z, depth, last};
            contact_count++;
            if (pending_contacts.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected contact %p", got);
            end else begin
                want = pending_contacts.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("contact mismatch: expected %p, got %p", want, got);
                end
            end
        end
    end

    // watchdog on cycles without any accepted request or result
    always @(posedge clk) begin
        if ((box_valid && !box_stall) || (contact_valid && !contact_stall)
                || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            timed_out = 1'b1;
            $display("tb_box_plane_contact failed");
            $finish;
        end
    end

    // directed table: centres mixed with plain and extreme, sign-flipped axes
    box_req_t directed [] = '{
        // centre before any axis load: point box at stored zeros
        centre_req(32'h0, 32'h0, 32'h0),
        centre_req(32'h0, 32'h0001_0000, 32'h0),
        axis_req(2'd0, 16'sd16384, 16'sd0, 16'sd0, 31'h0001_0000),
        axis_req(2'd1, 16'sd0, 16'sd16384, 16'sd0, 31'h0001_0000),
        axis_req(2'd2, 16'sd0, 16'sd0, 16'sd16384, 31'h0001_0000),
        centre_req(32'h0, 32'h0000_8000, 32'h0),
        centre_req(32'h0, 32'h0005_0000, 32'h0),
        centre_req(32'h7fffffff, 32'h80000000, 32'h7fffffff),
        axis_req(2'd0, 16'h8000, 16'h7fff, 16'h8000, 31'h7fffffff),
        axis_req(2'd1, 16'h7fff, 16'h8000, 16'h7fff, 31'h7fffffff),
        axis_req(2'd2, 16'hffff, 16'h0000, 16'h8000, 31'h7fffffff),
        centre_req(32'h80000000, 32'h7fffffff, 32'h80000000),
        centre_req(32'hffffffff, 32'h0, 32'h1)
    };

    // register settings visited between phases: normal x, y, z, offset, limit
    logic [31:0] cfg_sets [][5] = '{
        '{32'h0, 32'h4000, 32'h0, 32'h0, 32'h8},
        '{32'h8000, 32'h7fff, 32'hc000, 32'h80000000, 32'hf},
        '{32'h2d41, 32'h2d41, 32'h0, 32'h7fffffff, 32'h3},
        '{32'h7fff, 32'h8000, 32'h7fff, 32'h0002_0000, 32'h0},
        '{32'h0, 32'hc000, 32'h4000, 32'hfffe_0000, 32'h1},
        '{32'h4000, 32'h0, 32'h0, 32'h0, 32'h8}
    };

    initial begin
        box_req_t r;
        contact_t first_want;
        pl_axis = '{default: '{default: '0}};
        pl_half = '{default: '0};
        pl_n[0] = 16'sd0; pl_n[1] = 16'sd16384; pl_n[2] = 16'sd0;
        pl_offset = '0;
        pl_limit = 4'd8;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset defaults: point box at origin sits on the plane, so all eight
        // corners touch; the first is corner zero at depth zero, not the last
        send_box(directed[0]);
        first_want = contact_t'({1'b1, 3'd0, 96'd0, 31'd0, 1'b0});
        if (pending_contacts[0] !== first_want) begin
            mismatches++;
            if (mismatches <= 10)
                $display("reset contact mismatch: expected %p, got %p",
                         first_want, pending_contacts[0]);
        end
        for (int i = 1; i < directed.size(); i++) send_box(directed[i]);
        wait_drained();

        for (int p = 0; p < cfg_sets.size(); p++) begin
            for (int k = 0; k < 5; k++) write_reg(3'(k), cfg_sets[p][k]);
            // a write to an index past the register file is ignored
            if (p == 1) write_reg(3'd7, 32'hffff_ffff);
            cfg_valid <= 1'b0;
            // last phase runs without any idling
            idle_on = (p != cfg_sets.size() - 1);
            for (int b = 0; b < 11; b++) begin
                if ($urandom_range(0, 9) == 0) begin
                    r = '0;
                    r.slot = 2'($urandom_range(0, 3));
                    r.ax = 16'($urandom()); r.ay = 16'($urandom()); r.az = 16'($urandom());
                    r.half = 31'($urandom());
                    r.cx = $urandom(); r.cy = $urandom(); r.cz = $urandom();
                    send_box(r);
                end else begin
                    for (int s = 0; s < 3; s++)
                        send_box(axis_req(2'(s), rand_comp(), rand_comp(), rand_comp(),
                                          rand_half()));
                    send_box(centre_req(rand_pos(), rand_pos(), rand_pos()));
                end
            end
            // hold the sender until every expected contact has arrived
            wait_drained();
        end

        if (mismatches == 0 && pending_contacts.size() == 0)
            $display("tb_box_plane_contact passed");
        else
            $display("tb_box_plane_contact failed");
        $finish;
    end

endmodule
